### rtl/red_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// red_pkg
// Shared types, constants and helpers for the rotary encoder decoder.
// ----------------------------------------------------------------------------
package red_pkg;

    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 8;
    localparam int POS_OUT_W  = 16;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_HIT_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT = 2'd1;

    localparam logic [CFG_W-1:0] HIT_MIN_RESET   = 7'd2;
    localparam logic [CFG_W-1:0] HIT_LIMIT_RESET = 7'd4;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 8'sd127;
    localparam logic signed [CNT_W-1:0] CNT_MIN = -8'sd128;

    typedef logic signed [CNT_W-1:0] hit_cnt_t;

    typedef struct packed {
        logic stepped;
        logic step_up;
    } step_res_t;

    // Saturating +/-1 on a signed hit counter
    function automatic hit_cnt_t sat_step(input hit_cnt_t v, input logic up);
        hit_cnt_t r;
        if (up)
        begin
            r = (v == CNT_MAX) ? v : v + 8'sd1;
        end
        else
        begin
            r = (v == CNT_MIN) ? v : v - 8'sd1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/red_debounce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// red_debounce
// Push button debounce with a signed saturating hit counter.
// ----------------------------------------------------------------------------
module red_debounce
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      pin,
    input  wire logic [red_pkg::CFG_W-1:0] hit_min,
    output logic                           pressed_next
);

    logic              acc_reg, acc_next;
    logic              state_reg, state_next;
    red_pkg::hit_cnt_t cnt_reg, cnt_next;

    red_pkg::hit_cnt_t         cnt_step;
    logic [red_pkg::CNT_W-1:0] cnt_mag;
    logic                      differ;
    logic                      hit;

    always_comb
    begin
        differ   = (pin != acc_reg);
        cnt_step = red_pkg::sat_step(cnt_reg, ~pin);
        // magnitude of -128 is 128, still fits unsigned 8 bits
        cnt_mag  = cnt_step[red_pkg::CNT_W-1] ? red_pkg::CNT_W'(-cnt_step)
                                               : red_pkg::CNT_W'(cnt_step);
        hit      = differ && (cnt_mag > {1'b0, hit_min});

        acc_next   = acc_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (en && differ)
        begin
            if (hit)
            begin
                acc_next   = pin;
                state_next = ~cnt_step[red_pkg::CNT_W-1];
                cnt_next   = '0;
            end
            else
            begin
                cnt_next = cnt_step;
            end
        end
        pressed_next = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 1'b0;
            state_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

### rtl/red_quad.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// red_quad
// Quadrature hit counting and wrapping position accumulator.
// ----------------------------------------------------------------------------
module red_quad
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      pin_a,
    input  wire logic                      pin_b,
    input  wire logic [red_pkg::CFG_W-1:0] hit_min,
    input  wire logic [red_pkg::CFG_W-1:0] hit_limit,
    output red_pkg::step_res_t             res,
    output logic [POSITION_WIDTH-1:0]      total_next
);

    logic                      a_acc_reg, a_acc_next;
    logic                      b_acc_reg, b_acc_next;
    red_pkg::hit_cnt_t         a_cnt_reg, a_cnt_next;
    red_pkg::hit_cnt_t         b_cnt_reg, b_cnt_next;
    logic [POSITION_WIDTH-1:0] total_reg;

    red_pkg::hit_cnt_t a_step;
    red_pkg::hit_cnt_t b_step;
    red_pkg::hit_cnt_t lim_pos;
    red_pkg::hit_cnt_t lim_neg;
    red_pkg::hit_cnt_t mn;
    logic              a_differ;
    logic              over;
    logic              under;
    logic              b_high;

    always_comb
    begin
        lim_pos  = $signed({1'b0, hit_limit});
        lim_neg  = -lim_pos;
        mn       = $signed({1'b0, hit_min});
        a_differ = (pin_a != a_acc_reg);
        a_step   = red_pkg::sat_step(a_cnt_reg, ~pin_a);
        b_step   = (pin_b != b_acc_reg) ? red_pkg::sat_step(b_cnt_reg, pin_b) : b_cnt_reg;
        over     = a_step > lim_pos;
        under    = a_step < lim_neg;
        b_high   = b_step > mn;

        res.stepped = en && a_differ && (over || under);
        res.step_up = res.stepped && (over ? ~b_high : b_high);

        a_acc_next = a_acc_reg;
        b_acc_next = b_acc_reg;
        a_cnt_next = a_cnt_reg;
        b_cnt_next = b_cnt_reg;
        total_next = total_reg;
        if (res.stepped)
        begin
            a_acc_next = pin_a;
            b_acc_next = pin_b;
            a_cnt_next = '0;
            b_cnt_next = '0;
            total_next = res.step_up ? total_reg + POSITION_WIDTH'(1)
                                     : total_reg - POSITION_WIDTH'(1);
        end
        else if (en && a_differ)
        begin
            a_cnt_next = a_step;
            b_cnt_next = b_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_acc_reg <= 1'b0;
            b_acc_reg <= 1'b0;
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            a_acc_reg <= a_acc_next;
            b_acc_reg <= b_acc_next;
            a_cnt_reg <= a_cnt_next;
            b_cnt_reg <= b_cnt_next;
            total_reg <= total_next;
        end
    end

endmodule
`default_nettype wire

### rtl/rotary_encoder_debounced_decoder.sv
// An accepted sample waits in the input register; its result is registered
// for m_tdata. Throughput: one sample per cycle unless m_tready stalls it; the
// counter update between input and result register is one pass, no iteration.
// Reset (rst_n low, asynchronous): counters, accepted levels, position and
// button state clear; hit_min returns to 2, hit_limit to 4; no result pending.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_encoder_debounced_decoder
// Quadrature encoder decoder with debounced push button, one result per tick while m_tready does not stall it.
// ----------------------------------------------------------------------------
module rotary_encoder_debounced_decoder
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [0] pin_a, [1] pin_b, [2] pin_push, [7:3] zero
    input  wire logic [red_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] position, [16] pressed, [17] stepped, [18] step_up, [23:19] zero
    output logic [red_pkg::M_DATA_W-1:0]       m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [red_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [red_pkg::CFG_W-1:0]     cfg_data
);

    logic [red_pkg::CFG_W-1:0] hit_min_reg;
    logic [red_pkg::CFG_W-1:0] hit_limit_reg;

    logic                         in_valid_reg;
    logic [2:0]                   pins_reg;
    logic                         out_valid_reg;
    logic [red_pkg::POS_OUT_W-1:0] position_reg;
    logic                         pressed_reg;
    logic                         stepped_reg;
    logic                         step_up_reg;

    logic                          advance;
    logic                          fire;
    logic                          pressed_next;
    red_pkg::step_res_t            step_res;
    logic [POSITION_WIDTH-1:0]     total_next;
    logic [red_pkg::POS_OUT_W-1:0] position_next;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_min_reg   <= red_pkg::HIT_MIN_RESET;
            hit_limit_reg <= red_pkg::HIT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == red_pkg::REG_HIT_MIN)
            begin
                hit_min_reg <= cfg_data;
            end
            else if (cfg_index == red_pkg::REG_HIT_LIMIT)
            begin
                hit_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pins_reg <= s_tdata[2:0];
        end
    end

    red_debounce u_debounce
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (fire),
        .pin          (pins_reg[2]),
        .hit_min      (hit_min_reg),
        .pressed_next (pressed_next)
    );

    red_quad #(.POSITION_WIDTH(POSITION_WIDTH)) u_quad
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (fire),
        .pin_a      (pins_reg[0]),
        .pin_b      (pins_reg[1]),
        .hit_min    (hit_min_reg),
        .hit_limit  (hit_limit_reg),
        .res        (step_res),
        .total_next (total_next)
    );

    generate
        if (POSITION_WIDTH >= red_pkg::POS_OUT_W)
        begin : g_pos_cut
            assign position_next = total_next[red_pkg::POS_OUT_W-1:0];
        end
        else
        begin : g_pos_ext
            assign position_next = {{(red_pkg::POS_OUT_W-POSITION_WIDTH)
                                     {total_next[POSITION_WIDTH-1]}}, total_next};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
            pressed_reg   <= 1'b0;
            stepped_reg   <= 1'b0;
            step_up_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                position_reg <= position_next;
                pressed_reg  <= pressed_next;
                stepped_reg  <= step_res.stepped;
                step_up_reg  <= step_res.step_up;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, step_up_reg, stepped_reg, pressed_reg, position_reg};

`ifndef NO_ASSERTIONS
    a_up_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        step_up_reg |-> stepped_reg)
        else $error("step_up set without a step");

    a_hold_position: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !step_res.stepped |=> position_reg == $past(position_reg))
        else $error("position moved on a request without a step");

    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed request produced no result");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(pins_reg))
        else $error("pending request lost while stalled");
`endif

endmodule
`default_nettype wire
